// File: hw/rtl/imu_ufp_pkg.sv
`default_nettype none

package imu_ufp_pkg;

    localparam int BYTE_W  = 8;
    localparam int RAW_W   = 16;
    localparam int ACCEL_W = 13;
    localparam int RATE_W  = 20;
    localparam int TILT_W  = 17;
    localparam int FRAC_SHIFT = 7;

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h51;
    localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;
    localparam logic [BYTE_W-1:0] TYPE_TILT  = 8'h53;

    localparam int FRAME_LEN   = 11;
    localparam int PAYLOAD_LEN = 6;
    localparam int AXES        = 3;

    // Scale factors: full scale of each sensor.
    localparam int K_ACCEL = 16;
    localparam logic signed [11:0] K_RATE = 12'sd2000;
    localparam logic signed [8:0]  K_TILT = 9'sd180;

    localparam int ACCEL_SHIFT = FRAC_SHIFT - $clog2(K_ACCEL);
    localparam int RATE_PW = RAW_W + 11;
    localparam int TILT_PW = RAW_W + 9;

    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_TILT  = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // Multiplying by 16 and shifting right by 7 is a plain arithmetic shift.
    function automatic logic signed [ACCEL_W-1:0] scale_accel(input logic [RAW_W-1:0] raw);
        logic signed [RAW_W-1:0] s;
        s = signed'(raw);
        return ACCEL_W'(s >>> ACCEL_SHIFT);
    endfunction

    function automatic logic signed [RATE_W-1:0] scale_rate(input logic [RAW_W-1:0] raw);
        logic signed [RATE_PW-1:0] p;
        p = RATE_PW'(signed'(raw)) * RATE_PW'(K_RATE);
        return RATE_W'(p >>> FRAC_SHIFT);
    endfunction

    function automatic logic signed [TILT_W-1:0] scale_tilt(input logic [RAW_W-1:0] raw);
        logic signed [TILT_PW-1:0] p;
        p = TILT_PW'(signed'(raw)) * TILT_PW'(K_TILT);
        return TILT_W'(p >>> FRAC_SHIFT);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/imu_ufp_if.sv
`default_nettype none

interface imu_ufp_byte_if;
    logic                                valid;
    logic                                ready;
    logic [imu_ufp_pkg::BYTE_W-1:0]      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface imu_ufp_frame_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             frame_kind;
    logic signed [imu_ufp_pkg::ACCEL_W-1:0] accel_x;
    logic signed [imu_ufp_pkg::ACCEL_W-1:0] accel_y;
    logic signed [imu_ufp_pkg::ACCEL_W-1:0] accel_z;
    logic signed [imu_ufp_pkg::RATE_W-1:0]  rate_x;
    logic signed [imu_ufp_pkg::RATE_W-1:0]  rate_y;
    logic signed [imu_ufp_pkg::RATE_W-1:0]  rate_z;
    logic signed [imu_ufp_pkg::TILT_W-1:0]  tilt_x;
    logic signed [imu_ufp_pkg::TILT_W-1:0]  tilt_y;
    logic signed [imu_ufp_pkg::TILT_W-1:0]  tilt_z;

    modport source (
        output valid, output frame_kind,
        output accel_x, output accel_y, output accel_z,
        output rate_x, output rate_y, output rate_z,
        output tilt_x, output tilt_y, output tilt_z,
        input ready
    );
    modport sink (
        input valid, input frame_kind,
        input accel_x, input accel_y, input accel_z,
        input rate_x, input rate_y, input rate_z,
        input tilt_x, input tilt_y, input tilt_z,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/imu_uart_frame_parser.sv
`default_nettype none

// Channel  Dir  Payload                                   Item
// rx       in   rx_byte[7:0]                              one received serial byte
// frame    out  frame_kind, accel_*, rate_*, tilt_*       one decoded frame, all nine values
//
// One byte is taken per cycle while nothing is stalled; once a frame's last byte is
// taken, its result goes through the parser stage, then the scaling multipliers that
// feed the output register. Reset clears the byte counter, the stored triples and both
// result stages. A stalled output holds one result in the output register and one in the
// parser stage; input is refused only when both are full.
module imu_uart_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    imu_ufp_byte_if.sink     rx,
    imu_ufp_frame_if.source  frame
);

    localparam logic [3:0] LAST_POS = 4'(imu_ufp_pkg::FRAME_LEN - 1);
    localparam logic [3:0] PAY_FIRST = 4'd2;
    localparam logic [3:0] PAY_LAST = 4'(imu_ufp_pkg::PAYLOAD_LEN + 1);

    logic [3:0] byte_count_reg, byte_count_next;
    logic [7:0] frame_type_reg;
    logic [7:0] payload_reg [imu_ufp_pkg::PAYLOAD_LEN];
    logic [15:0] accel_raw_reg [imu_ufp_pkg::AXES];
    logic [15:0] rate_raw_reg [imu_ufp_pkg::AXES];
    logic [15:0] tilt_raw_reg [imu_ufp_pkg::AXES];
    logic [15:0] triple [imu_ufp_pkg::AXES];
    logic [2:0] pay_idx;

    logic done_reg;
    imu_ufp_pkg::kind_t done_kind_reg;
    imu_ufp_pkg::kind_t kind;

    logic out_valid_reg;
    imu_ufp_pkg::kind_t out_kind_reg;
    logic signed [imu_ufp_pkg::ACCEL_W-1:0] accel_out_reg [imu_ufp_pkg::AXES];
    logic signed [imu_ufp_pkg::RATE_W-1:0]  rate_out_reg [imu_ufp_pkg::AXES];
    logic signed [imu_ufp_pkg::TILT_W-1:0]  tilt_out_reg [imu_ufp_pkg::AXES];

    logic slot_free;
    logic in_fire;
    logic last_byte;
    logic pay_write;

    assign slot_free = !out_valid_reg || frame.ready;
    assign rx.ready  = !done_reg || slot_free;
    assign in_fire   = rx.valid && rx.ready;
    assign last_byte = in_fire && (byte_count_reg == LAST_POS);
    assign pay_write = in_fire && (byte_count_reg >= PAY_FIRST) && (byte_count_reg <= PAY_LAST);
    assign pay_idx   = 3'(byte_count_reg - PAY_FIRST);

    always_comb
    begin
        priority if (!in_fire)
        begin
            byte_count_next = byte_count_reg;
        end
        else if (byte_count_reg == 4'd0)
        begin
            byte_count_next = (rx.rx_byte == imu_ufp_pkg::HDR_BYTE) ? 4'd1 : 4'd0;
        end
        else if (byte_count_reg == LAST_POS)
        begin
            byte_count_next = 4'd0;
        end
        else
        begin
            byte_count_next = byte_count_reg + 4'd1;
        end
    end

    always_comb
    begin
        unique case (frame_type_reg)
            imu_ufp_pkg::TYPE_ACCEL: kind = imu_ufp_pkg::KIND_ACCEL;
            imu_ufp_pkg::TYPE_RATE:  kind = imu_ufp_pkg::KIND_RATE;
            imu_ufp_pkg::TYPE_TILT:  kind = imu_ufp_pkg::KIND_TILT;
            default:                 kind = imu_ufp_pkg::KIND_OTHER;
        endcase
    end

    // Payload words are little endian: low byte first.
    always_comb
    begin
        for (int i = 0; i < imu_ufp_pkg::AXES; i++)
        begin
            triple[i] = {payload_reg[2*i+1], payload_reg[2*i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 4'd0;
            frame_type_reg <= 8'd0;
            done_reg       <= 1'b0;
            done_kind_reg  <= imu_ufp_pkg::KIND_OTHER;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= imu_ufp_pkg::KIND_OTHER;
            for (int i = 0; i < imu_ufp_pkg::AXES; i++)
            begin
                accel_raw_reg[i] <= 16'd0;
                rate_raw_reg[i]  <= 16'd0;
                tilt_raw_reg[i]  <= 16'd0;
            end
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            if (in_fire && byte_count_reg == 4'd1)
            begin
                frame_type_reg <= rx.rx_byte;
            end

            if (last_byte)
            begin
                for (int i = 0; i < imu_ufp_pkg::AXES; i++)
                begin
                    if (kind == imu_ufp_pkg::KIND_ACCEL)
                    begin
                        accel_raw_reg[i] <= triple[i];
                    end
                    if (kind == imu_ufp_pkg::KIND_RATE)
                    begin
                        rate_raw_reg[i] <= triple[i];
                    end
                    if (kind == imu_ufp_pkg::KIND_TILT)
                    begin
                        tilt_raw_reg[i] <= triple[i];
                    end
                end
            end

            if (last_byte)
            begin
                done_reg      <= 1'b1;
                done_kind_reg <= kind;
            end
            else if (slot_free)
            begin
                done_reg <= 1'b0;
            end

            if (slot_free)
            begin
                out_valid_reg <= done_reg;
                if (done_reg)
                begin
                    out_kind_reg <= done_kind_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_write)
        begin
            payload_reg[pay_idx] <= rx.rx_byte;
        end
    end

    // The stored triples cannot change while a finished frame waits here, so the
    // scaling reads them straight from the raw registers.
    always_ff @(posedge clk)
    begin
        if (slot_free && done_reg)
        begin
            for (int i = 0; i < imu_ufp_pkg::AXES; i++)
            begin
                accel_out_reg[i] <= imu_ufp_pkg::scale_accel(accel_raw_reg[i]);
                rate_out_reg[i]  <= imu_ufp_pkg::scale_rate(rate_raw_reg[i]);
                tilt_out_reg[i]  <= imu_ufp_pkg::scale_tilt(tilt_raw_reg[i]);
            end
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_kind = out_kind_reg;
    assign frame.accel_x    = accel_out_reg[0];
    assign frame.accel_y    = accel_out_reg[1];
    assign frame.accel_z    = accel_out_reg[2];
    assign frame.rate_x     = rate_out_reg[0];
    assign frame.rate_y     = rate_out_reg[1];
    assign frame.rate_z     = rate_out_reg[2];
    assign frame.tilt_x     = tilt_out_reg[0];
    assign frame.tilt_y     = tilt_out_reg[1];
    assign frame.tilt_z     = tilt_out_reg[2];

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= LAST_POS)
        else $error("byte counter beyond frame length");

    a_last_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |=> done_reg && byte_count_reg == 4'd0)
        else $error("completed frame not handed to result stage");

    a_done_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> byte_count_reg == 4'd0)
        else $error("new frame started while a result waits");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done_reg))
        else $error("result appeared without a completed frame");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !slot_free |=> done_reg)
        else $error("pending result lost under stall");
`endif

endmodule

`default_nettype wire
